FILE: src/itrs_pkg.sv
// shared constants and the digit-to-character function of the radix string converter
`default_nettype none

package itrs_pkg;

  // radix limits; radix values outside this range are clamped to the nearest bound
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;

  // digit mapping
  localparam logic [5:0] DIGIT_LIMIT   = 6'd9;
  localparam logic [6:0] LETTER_OFFSET = 7'd10;
  localparam logic [6:0] CHAR_ZERO     = 7'h30;
  localparam logic [6:0] CHAR_LETTER_A = 7'h41;
  localparam logic [6:0] CHAR_MINUS    = 7'h2D;

  // magnitude bits consumed by the divider in one cycle
  localparam int unsigned STEP_BITS = 8;

  // entries of the queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // remainder digit to ascii character
  function automatic logic [6:0] digit_char(input logic [5:0] digit);
    logic [6:0] wide;
    wide = {1'b0, digit};
    if (digit > DIGIT_LIMIT) begin
      return wide - LETTER_OFFSET + CHAR_LETTER_A;
    end else begin
      return wide + CHAR_ZERO;
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/itrs_if.sv
// stream interfaces for the number input and the character output
`default_nettype none

interface itrs_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [5:0]             radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itrs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: src/integer_to_radix_string_unit.sv
// Integer to radix string converter: signed VALUE_WIDTH-bit number in, ascii characters out.
// Each digit comes from the divider in chunks of 8 magnitude bits; a number is taken, divided
// digit by digit into the digit ram, its first digit fetched, then its characters go out one
// per cycle while the sink is ready.
// A two-entry queue takes new numbers while the converter is busy; one number at a time.
// Reset clears all control state; the digit ram is not cleared and needs no clearing pass.
`default_nettype none

module integer_to_radix_string_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itrs_in_if.sink   in_i,
  itrs_out_if.source out_o
);

  localparam int unsigned JW = VALUE_WIDTH + 6 + 1;

  logic                   fr_valid, fr_ready;
  logic [VALUE_WIDTH-1:0] fr_mag;
  logic [5:0]             fr_radix;
  logic                   fr_neg;
  logic                   bk_valid, bk_ready;
  logic [JW-1:0]          bk_data;

  // classify incoming numbers
  itrs_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .value_i     (in_i.value),
    .radix_i     (in_i.radix),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_mag_o   (fr_mag),
    .job_radix_o (fr_radix),
    .job_neg_o   (fr_neg)
  );

  // decoupling queue
  itrs_queue #(
    .WIDTH (JW),
    .DEPTH (itrs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_neg, fr_radix, fr_mag}),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  // conversion and character output
  itrs_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bk_valid),
    .job_ready_o  (bk_ready),
    .job_mag_i    (bk_data[VALUE_WIDTH-1:0]),
    .job_radix_i  (bk_data[VALUE_WIDTH+5:VALUE_WIDTH]),
    .job_neg_i    (bk_data[JW-1]),
    .char_valid_o (out_o.valid),
    .char_ready_i (out_o.ready),
    .character_o  (out_o.character),
    .last_o       (out_o.last)
  );

endmodule

`default_nettype wire

FILE: src/itrs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module itrs_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/itrs_queue.sv
// small first-in first-out queue between the classifying front end and the converter
`default_nettype none

module itrs_queue #(
  parameter int unsigned WIDTH = 39,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != CW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/itrs_front.sv
// front end: takes input numbers, clamps the radix and splits sign and magnitude
`default_nettype none

module itrs_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic [5:0]             radix_i,
  output logic                        job_valid_o,
  input  wire logic                   job_ready_i,
  output logic      [VALUE_WIDTH-1:0] job_mag_o,
  output logic      [5:0]             job_radix_o,
  output logic                        job_neg_o
);

  // transfer goes straight into the queue
  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

  // sign and unsigned magnitude; the most negative value maps to its true magnitude
  assign job_neg_o = value_i[VALUE_WIDTH-1];
  assign job_mag_o = job_neg_o ? (~value_i + 1'b1) : value_i;

  // radix clamp to the supported range
  always_comb begin
    if (radix_i < itrs_pkg::RADIX_MIN) begin
      job_radix_o = itrs_pkg::RADIX_MIN;
    end else if (radix_i > itrs_pkg::RADIX_MAX) begin
      job_radix_o = itrs_pkg::RADIX_MAX;
    end else begin
      job_radix_o = radix_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/itrs_back.sv
// back end: repeated division by the radix into a digit ram, then character emission
`default_nettype none

module itrs_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  output logic                        job_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] job_mag_i,
  input  wire logic [5:0]             job_radix_i,
  input  wire logic                   job_neg_i,
  output logic                        char_valid_o,
  input  wire logic                   char_ready_i,
  output logic      [6:0]             character_o,
  output logic                        last_o
);

  localparam int unsigned STEP   = itrs_pkg::STEP_BITS;
  localparam int unsigned CHUNKS = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int unsigned PW     = CHUNKS * STEP;
  localparam int unsigned AW     = $clog2(VALUE_WIDTH);
  localparam int unsigned KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_FETCH,
    S_LOAD
  } state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] mag_q, mag_d;
  logic [5:0]    radix_q, radix_d;
  logic          neg_q, neg_d;
  logic [5:0]    rem_q, rem_d;
  logic [KW-1:0] chunk_q, chunk_d;
  logic [AW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          char_valid_q, char_valid_d;
  logic [6:0]    char_q, char_d;
  logic          last_q, last_d;

  logic [PW-1:0] mag_next;
  logic [5:0]    rem_next;
  logic [STEP-1:0] qbits;
  logic          out_free;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [5:0]    ram_rdata;

  // one radix-2 long division step per magnitude bit, a chunk of bits per cycle
  always_comb begin
    logic [6:0]      trial;
    logic [5:0]      part;
    logic [STEP-1:0] chunk;
    part  = rem_q;
    chunk = mag_q[PW-1 -: STEP];
    qbits = '0;
    for (int i = STEP - 1; i >= 0; i--) begin
      trial = {part, chunk[i]};
      if (trial >= {1'b0, radix_q}) begin
        trial    = trial - {1'b0, radix_q};
        qbits[i] = 1'b1;
      end
      part = trial[5:0];
    end
    rem_next = part;
    mag_next = (mag_q << STEP) | PW'(qbits);
  end

  assign out_free    = !char_valid_q || char_ready_i;
  assign job_ready_o = (state_q == S_IDLE);
  assign ram_we      = (state_q == S_DIV) && (chunk_q == '0);

  // sequencer: division loop, then sign and digits most significant first
  always_comb begin
    state_d      = state_q;
    mag_d        = mag_q;
    radix_d      = radix_q;
    neg_d        = neg_q;
    rem_d        = rem_q;
    chunk_d      = chunk_q;
    count_d      = count_q;
    idx_d        = idx_q;
    char_valid_d = char_valid_q;
    char_d       = char_q;
    last_d       = last_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    if (char_valid_q && char_ready_i) begin
      char_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          mag_d   = PW'(job_mag_i);
          radix_d = job_radix_i;
          neg_d   = job_neg_i;
          rem_d   = '0;
          chunk_d = KW'(CHUNKS - 1);
          count_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        mag_d = mag_next;
        rem_d = rem_next;
        if (chunk_q == '0) begin
          // digit done and written; stop on zero quotient or full store
          rem_d   = '0;
          chunk_d = KW'(CHUNKS - 1);
          if (mag_next == '0 || count_q == AW'(VALUE_WIDTH - 1)) begin
            idx_d   = count_q;
            state_d = neg_q ? S_SIGN : S_FETCH;
          end else begin
            count_d = count_q + 1'b1;
          end
        end else begin
          chunk_d = chunk_q - 1'b1;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          char_valid_d = 1'b1;
          char_d       = itrs_pkg::CHAR_MINUS;
          last_d       = 1'b0;
          state_d      = S_FETCH;
        end
      end
      S_FETCH: begin
        ram_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          char_valid_d = 1'b1;
          char_d       = itrs_pkg::digit_char(ram_rdata);
          last_d       = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            // fetch the next lower digit while this one goes out
            ram_re    = 1'b1;
            ram_raddr = idx_q - 1'b1;
            idx_d     = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      char_valid_q <= 1'b0;
      chunk_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      rem_q        <= '0;
      mag_q        <= '0;
      neg_q        <= 1'b0;
      radix_q      <= '0;
      char_q       <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      char_valid_q <= char_valid_d;
      chunk_q      <= chunk_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      rem_q        <= rem_d;
      mag_q        <= mag_d;
      neg_q        <= neg_d;
      radix_q      <= radix_d;
      char_q       <= char_d;
      last_q       <= last_d;
    end
  end

  // digit store, least significant digit at address zero
  itrs_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q),
    .wdata_i (rem_next),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign char_valid_o = char_valid_q;
  assign character_o  = char_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
